>>> hdl/lvc_pkg.sv
package lvc_pkg;

   // number of stored clip planes of a spot light
   localparam int NUM_PLANES = 6;

   // sqrt(3) with 16 fraction bits
   localparam logic [16:0] SQRT3_Q16 = 17'd113512;

   // configuration register indexes
   localparam logic [2:0] CSR_LIGHT_MODE  = 3'd0;
   localparam logic [2:0] CSR_LIGHT_POS_X = 3'd1;
   localparam logic [2:0] CSR_LIGHT_POS_Y = 3'd2;
   localparam logic [2:0] CSR_LIGHT_POS_Z = 3'd3;
   localparam logic [2:0] CSR_ATT_END     = 3'd4;

   // light modes and item commands
   localparam logic MODE_SPOT = 1'b0;
   localparam logic MODE_OMNI = 1'b1;
   localparam logic CMD_WRITE_PLANE = 1'b0;
   localparam logic CMD_CLASSIFY    = 1'b1;

   typedef enum logic [1:0] {
      COV_OUTSIDE = 2'd0,
      COV_PARTIAL = 2'd1,
      COV_INSIDE  = 2'd2
   } cov_type;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic signed [15:0] off;
   } plane_type;

   // per-plane result: cube wholly behind, cube not wholly in front
   typedef struct packed {
      logic behind;
      logic not_front;
   } plane_flags_type;

   // sphere result: cube wholly inside, cube touches the sphere
   typedef struct packed {
      logic enclosed;
      logic touch;
   } sph_flags_type;

endpackage

>>> hdl/light_volume_cube_classify.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | command, plane fields, cube centre and size
// rsp     | out       | rsp_valid/rsp_ready  | coverage
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// one item per cycle while the output is not stalled; a classify item's coverage passes the stages
// (input register, products, sums and squares, compares, output register)
// plane write items update the table as they leave the input register and give no result
// synchronous reset zeroes valid bits, plane table, light position and radius, sets omni mode
// csr is always ready; a stalled output freezes the whole pipeline, so nothing is lost or repeated
module light_volume_cube_classify import lvc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic        [2:0]  req_plane_index,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic signed [15:0] req_plane_offset,
   input  logic signed [15:0] req_center_x,
   input  logic signed [15:0] req_center_y,
   input  logic signed [15:0] req_center_z,
   input  logic        [14:0] req_cube_size,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [1:0]  rsp_coverage,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [2:0]  csr_index,
   input  logic        [15:0] csr_wdata
);

   logic               light_mode_ff;
   logic signed [15:0] light_pos_x_ff, light_pos_y_ff, light_pos_z_ff;
   logic        [14:0] att_end_ff;

   plane_type          plane_table_ff [NUM_PLANES];

   logic               adv;
   logic               v0_ff, v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic               cmd0_ff;
   logic        [2:0]  idx0_ff;
   plane_type          plane0_ff;
   logic signed [15:0] cx0_ff, cy0_ff, cz0_ff;
   logic        [14:0] size0_ff;
   logic        [32:0] r_prod;
   logic        [19:0] r1_ff, r1_in, r2_ff;
   logic               plane_wr;
   cov_type            cov_ff, cov_in;

   plane_flags_type    plane_flags [NUM_PLANES];
   sph_flags_type      sph_flags;
   logic               any_behind, any_not_front;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign plane_wr  = v0_ff && (cmd0_ff == CMD_WRITE_PLANE) && adv
                   && ({1'b0, idx0_ff} < 4'(NUM_PLANES));

   // bounding radius at 4 fraction bits, rounded half up
   assign r_prod = 33'(size0_ff) * 33'(SQRT3_Q16) + 33'd2048;
   assign r1_in  = r_prod[31:12];

   always_ff @(posedge clock) begin
      if (reset) begin
         light_mode_ff  <= MODE_OMNI;
         light_pos_x_ff <= '0;
         light_pos_y_ff <= '0;
         light_pos_z_ff <= '0;
         att_end_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LIGHT_MODE:  light_mode_ff  <= csr_wdata[0];
            CSR_LIGHT_POS_X: light_pos_x_ff <= csr_wdata;
            CSR_LIGHT_POS_Y: light_pos_y_ff <= csr_wdata;
            CSR_LIGHT_POS_Z: light_pos_z_ff <= csr_wdata;
            CSR_ATT_END:     att_end_ff     <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            plane_table_ff[p] <= '0;
         end
      end else if (plane_wr) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            if ({1'b0, idx0_ff} == 4'(p)) begin
               plane_table_ff[p] <= plane0_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v0_ff        <= req_valid;
         // write items end in the input register
         v1_ff        <= v0_ff && (cmd0_ff == CMD_CLASSIFY);
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd0_ff   <= req_command;
         idx0_ff   <= req_plane_index;
         plane0_ff <= '{nx: req_normal_x, ny: req_normal_y, nz: req_normal_z,
                        off: req_plane_offset};
         cx0_ff    <= req_center_x;
         cy0_ff    <= req_center_y;
         cz0_ff    <= req_center_z;
         size0_ff  <= req_cube_size;
         r1_ff     <= r1_in;
         r2_ff     <= r1_ff;
         cov_ff    <= cov_in;
      end
   end

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      lvc_plane_eval u_plane (
         .clock  (clock),
         .adv    (adv),
         .entry  (plane_table_ff[p]),
         .cx     (cx0_ff),
         .cy     (cy0_ff),
         .cz     (cz0_ff),
         .radius (r2_ff),
         .flags  (plane_flags[p])
      );
   end

   lvc_sphere_eval u_sphere (
      .clock   (clock),
      .adv     (adv),
      .pos_x   (light_pos_x_ff),
      .pos_y   (light_pos_y_ff),
      .pos_z   (light_pos_z_ff),
      .att_end (att_end_ff),
      .cx      (cx0_ff),
      .cy      (cy0_ff),
      .cz      (cz0_ff),
      .radius  (r1_ff),
      .flags   (sph_flags)
   );

   always_comb begin
      any_behind    = 1'b0;
      any_not_front = 1'b0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         any_behind    = any_behind    | plane_flags[p].behind;
         any_not_front = any_not_front | plane_flags[p].not_front;
      end
   end

   always_comb begin
      if (light_mode_ff == MODE_SPOT) begin
         if (any_behind)         cov_in = COV_OUTSIDE;
         else if (any_not_front) cov_in = COV_PARTIAL;
         else                    cov_in = COV_INSIDE;
      end else begin
         if (sph_flags.enclosed)   cov_in = COV_INSIDE;
         else if (sph_flags.touch) cov_in = COV_PARTIAL;
         else                      cov_in = COV_OUTSIDE;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_coverage = cov_ff;

   // a stalled output holds the valid bits of the compute stages
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(v3_ff) && $stable(v2_ff) && $stable(v1_ff)))
      else $error("pipeline moved while the output was stalled");

   // a write item never reaches the compute stages
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (adv && v0_ff && (cmd0_ff == CMD_WRITE_PLANE)) |=> !v1_ff)
      else $error("plane write item entered the classify pipeline");

   // inside the inner sphere implies inside the outer one
   a_sphere_nesting: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && sph_flags.enclosed) |-> sph_flags.touch)
      else $error("sphere inner test passed while outer test failed");

   // coverage code is never the unused value
   a_cov_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (cov_ff == COV_OUTSIDE || cov_ff == COV_PARTIAL
                        || cov_ff == COV_INSIDE))
      else $error("reserved coverage code on output");

endmodule

>>> hdl/lvc_plane_eval.sv
module lvc_plane_eval import lvc_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  plane_type          entry,
   input  logic signed [15:0] cx,
   input  logic signed [15:0] cy,
   input  logic signed [15:0] cz,
   input  logic        [19:0] radius,
   output plane_flags_type    flags
);

   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [31:0] px_in, py_in, pz_in;
   logic signed [15:0] off_ff;
   logic signed [33:0] dist_ff, dist_in;
   logic signed [33:0] lim;
   plane_flags_type    flags_ff, flags_in;

   assign px_in = entry.nx * cx;
   assign py_in = entry.ny * cy;
   assign pz_in = entry.nz * cz;

   // distance at 14 fraction bits
   assign dist_in = 34'(px_ff) + 34'(py_ff) + 34'(pz_ff)
                  + {{4{off_ff[15]}}, off_ff, 14'b0};

   assign lim = signed'({4'b0, radius, 10'b0});

   assign flags_in.behind    = (dist_ff <= -lim);
   assign flags_in.not_front = (dist_ff <= lim);

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         off_ff   <= entry.off;
         dist_ff  <= dist_in;
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

>>> hdl/lvc_sphere_eval.sv
module lvc_sphere_eval import lvc_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [15:0] pos_x,
   input  logic signed [15:0] pos_y,
   input  logic signed [15:0] pos_z,
   input  logic        [14:0] att_end,
   input  logic signed [15:0] cx,
   input  logic signed [15:0] cy,
   input  logic signed [15:0] cz,
   input  logic        [19:0] radius,
   output sph_flags_type      flags
);

   logic signed [16:0] dx_ff, dy_ff, dz_ff;
   logic signed [16:0] dx_in, dy_in, dz_in;
   logic signed [33:0] sqx_full, sqy_full, sqz_full;
   logic        [31:0] sqx_ff, sqy_ff, sqz_ff;
   logic        [18:0] att_scaled;
   logic        [20:0] outer_ff, outer_in;
   logic        [19:0] inner_ff, inner_in;
   logic               a_gt_r_ff, a_gt_r_in;
   logic        [41:0] d2_ff, d2_in;
   logic        [41:0] outer_sq_ff, outer_sq_in;
   logic        [41:0] inner_sq_ff, inner_sq_in;
   logic               a_gt_r3_ff;

   assign dx_in = {pos_x[15], pos_x} - {cx[15], cx};
   assign dy_in = {pos_y[15], pos_y} - {cy[15], cy};
   assign dz_in = {pos_z[15], pos_z} - {cz[15], cz};

   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;
   assign sqz_full = dz_ff * dz_ff;

   // radius at 4 fraction bits
   assign att_scaled = {att_end, 4'b0};
   assign outer_in   = 21'(att_scaled) + 21'(radius);
   assign a_gt_r_in  = 20'(att_scaled) > radius;
   assign inner_in   = a_gt_r_in ? (20'(att_scaled) - radius) : 20'd0;

   assign d2_in       = {34'(sqx_ff) + 34'(sqy_ff) + 34'(sqz_ff), 8'b0};
   assign outer_sq_in = outer_ff * outer_ff;
   assign inner_sq_in = 42'(inner_ff * inner_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff       <= dx_in;
         dy_ff       <= dy_in;
         dz_ff       <= dz_in;
         sqx_ff      <= sqx_full[31:0];
         sqy_ff      <= sqy_full[31:0];
         sqz_ff      <= sqz_full[31:0];
         outer_ff    <= outer_in;
         inner_ff    <= inner_in;
         a_gt_r_ff   <= a_gt_r_in;
         d2_ff       <= d2_in;
         outer_sq_ff <= outer_sq_in;
         inner_sq_ff <= inner_sq_in;
         a_gt_r3_ff  <= a_gt_r_ff;
      end
   end

   assign flags.enclosed = a_gt_r3_ff && (d2_ff < inner_sq_ff);
   assign flags.touch    = (d2_ff <= outer_sq_ff);

endmodule

>>> tb/sv/light_volume_cube_classify_test.sv
module light_volume_cube_classify_test;
   import lvc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 100;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_command = CMD_CLASSIFY;
   logic        [2:0]  req_plane_index = '0;
   logic signed [15:0] req_normal_x = '0;
   logic signed [15:0] req_normal_y = '0;
   logic signed [15:0] req_normal_z = '0;
   logic signed [15:0] req_plane_offset = '0;
   logic signed [15:0] req_center_x = '0;
   logic signed [15:0] req_center_y = '0;
   logic signed [15:0] req_center_z = '0;
   logic        [14:0] req_cube_size = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic        [1:0]  rsp_coverage;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic        [2:0]  csr_index = '0;
   logic        [15:0] csr_wdata = '0;

   // mirror of the block's plane table and light registers
   logic signed [15:0] plane_nx [NUM_PLANES] = '{default: '0};
   logic signed [15:0] plane_ny [NUM_PLANES] = '{default: '0};
   logic signed [15:0] plane_nz [NUM_PLANES] = '{default: '0};
   logic signed [15:0] plane_off [NUM_PLANES] = '{default: '0};
   logic               light_mode = MODE_OMNI;
   logic signed [15:0] light_x = '0;
   logic signed [15:0] light_y = '0;
   logic signed [15:0] light_z = '0;
   logic        [14:0] light_att = '0;

   cov_type coverage_due [$];
   cov_type coverage_want;

   int  cycle_count = 0;
   int  fail_count = 0;
   int  item_count = 0;
   int  plane_write_count = 0;
   int  setting_count = 0;
   int  coverage_seen [3] = '{default: 0};
   int  rsp_gap_left = 0;
   int  rsp_hold_left = 0;
   bit  sender_idle = 1'b1;
   bit  receiver_idle = 1'b1;

   light_volume_cube_classify i_dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  coverage_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic cov_type expected_coverage(input logic signed [15:0] cx_in,
                                                 input logic signed [15:0] cy_in,
                                                 input logic signed [15:0] cz_in,
                                                 input logic [14:0] size_in);
      longint cx, cy, cz, radius, lim, plane_d, dx, dy, dz, dist2, att, outer, inner;
      bit     fully;
      cx = cx_in;
      cy = cy_in;
      cz = cz_in;
      // bounding radius with 4 fraction bits, rounded half up
      radius = (longint'(size_in) * longint'(SQRT3_Q16) + 64'sd2048) >>> 12;
      if (light_mode == MODE_SPOT) begin
         lim = radius * 1024;
         fully = 1'b1;
         for (int p = 0; p < NUM_PLANES; p++) begin
            plane_d = longint'(plane_nx[p]) * cx + longint'(plane_ny[p]) * cy
                    + longint'(plane_nz[p]) * cz + longint'(plane_off[p]) * 16384;
            if (plane_d <= -lim)
               return COV_OUTSIDE;
            if (plane_d <= lim)
               fully = 1'b0;
         end
         return fully ? COV_INSIDE : COV_PARTIAL;
      end
      dx = longint'(light_x) - cx;
      dy = longint'(light_y) - cy;
      dz = longint'(light_z) - cz;
      dist2 = (dx * dx + dy * dy + dz * dz) * 256;
      att = longint'(light_att) * 16;
      outer = att + radius;
      if (att > radius) begin
         inner = att - radius;
         if (dist2 < inner * inner)
            return COV_INSIDE;
      end
      if (dist2 <= outer * outer)
         return COV_PARTIAL;
      return COV_OUTSIDE;
   endfunction

   // accepted items and register writes update the mirror in acceptance order
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         item_count++;
         if (req_command == CMD_WRITE_PLANE) begin
            plane_write_count++;
            if (req_plane_index < NUM_PLANES) begin
               plane_nx[req_plane_index] = req_normal_x;
               plane_ny[req_plane_index] = req_normal_y;
               plane_nz[req_plane_index] = req_normal_z;
               plane_off[req_plane_index] = req_plane_offset;
            end
         end else begin
            coverage_due.push_back(expected_coverage(req_center_x, req_center_y,
                                                     req_center_z, req_cube_size));
         end
      end
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LIGHT_MODE:  light_mode = csr_wdata[0];
            CSR_LIGHT_POS_X: light_x = csr_wdata;
            CSR_LIGHT_POS_Y: light_y = csr_wdata;
            CSR_LIGHT_POS_Z: light_z = csr_wdata;
            CSR_ATT_END:     light_att = csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (coverage_due.size() == 0) begin
            $error("coverage: expected nothing, got %0d", rsp_coverage);
            fail_count++;
         end else begin
            coverage_want = coverage_due.pop_front();
            if (rsp_coverage !== coverage_want) begin
               $error("coverage: expected %0d, got %0d", coverage_want, rsp_coverage);
               fail_count++;
            end
            if (coverage_want <= COV_INSIDE)
               coverage_seen[coverage_want]++;
         end
         rsp_gap_left = receiver_idle ? $urandom_range(0, 12) : 0;
      end
   end

   // result side: long hold-off first, then the per-item gap
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_gap_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic cmd, input logic [2:0] index,
                            input logic signed [15:0] nx, input logic signed [15:0] ny,
                            input logic signed [15:0] nz, input logic signed [15:0] off,
                            input logic signed [15:0] cx, input logic signed [15:0] cy,
                            input logic signed [15:0] cz, input logic [14:0] size);
      int gap;
      gap = sender_idle ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command <= cmd;
      req_plane_index <= index;
      req_normal_x <= nx;
      req_normal_y <= ny;
      req_normal_z <= nz;
      req_plane_offset <= off;
      req_center_x <= cx;
      req_center_y <= cy;
      req_center_z <= cz;
      req_cube_size <= size;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // cube fields of a plane write are don't-care, so fill them with noise
   task automatic send_plane(input logic [2:0] index, input logic signed [15:0] nx,
                             input logic signed [15:0] ny, input logic signed [15:0] nz,
                             input logic signed [15:0] off);
      send_item(CMD_WRITE_PLANE, index, nx, ny, nz, off, 16'($urandom), 16'($urandom),
                16'($urandom), 15'($urandom));
   endtask

   task automatic send_cube(input logic signed [15:0] cx, input logic signed [15:0] cy,
                            input logic signed [15:0] cz, input logic [14:0] size);
      send_item(CMD_CLASSIFY, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), cx, cy, cz, size);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // unused upper bits of the mode and radius registers get random values
   task automatic set_light(input logic mode, input logic signed [15:0] px,
                            input logic signed [15:0] py, input logic signed [15:0] pz,
                            input logic [14:0] att);
      logic [14:0] junk;
      junk = 15'($urandom);
      write_reg(CSR_LIGHT_MODE, {junk, mode});
      write_reg(CSR_LIGHT_POS_X, px);
      write_reg(CSR_LIGHT_POS_Y, py);
      write_reg(CSR_LIGHT_POS_Z, pz);
      write_reg(CSR_ATT_END, {junk[0], att});
      setting_count++;
   endtask

   // wait until every result is in and plane writes have left the pipeline
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (coverage_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767)
         return 16'sd32767;
      if (v < -32768)
         return -16'sd32768;
      return 16'(v);
   endfunction

   // axis-aligned box planes give a useful mix of outside, partial and inside
   task automatic send_random_plane(input logic [2:0] index, input bit box);
      logic signed [15:0] n [3];
      logic signed [15:0] extent;
      if (box && index < NUM_PLANES) begin
         n = '{default: '0};
         n[index / 2] = index[0] ? -16'sd16384 : 16'sd16384;
         extent = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32767));
      end else begin
         n[0] = 16'($urandom);
         n[1] = 16'($urandom);
         n[2] = 16'($urandom);
         extent = 16'($urandom);
      end
      send_plane(index, n[0], n[1], n[2], extent);
   endtask

   task automatic send_spot_cube();
      int pick;
      logic [14:0] size;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         size = '0;
      else if (pick < 4)
         size = 15'($urandom_range(0, 32767));
      else
         size = 15'($urandom_range(0, 1500));
      send_cube(16'($urandom), 16'($urandom), 16'($urandom), size);
   endtask

   task automatic send_omni_cube(input logic signed [15:0] px, input logic signed [15:0] py,
                                 input logic signed [15:0] pz, input logic [14:0] att);
      int span;
      span = int'(att) * 2 + 64;
      if ($urandom_range(0, 9) == 0)
         send_cube(16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom));
      else
         send_cube(clamp16(longint'(px) + $urandom_range(0, 2 * span) - span),
                   clamp16(longint'(py) + $urandom_range(0, 2 * span) - span),
                   clamp16(longint'(pz) + $urandom_range(0, 2 * span) - span),
                   15'($urandom_range(0, int'(att) / 8 + 40)));
   endtask

   task automatic test_reset_state();
      // omni with zero radius: only the exact light position touches
      send_cube(0, 0, 0, 0);
      send_cube(1, 0, 0, 0);
      settle();
   endtask

   task automatic test_spot_planes();
      set_light(MODE_SPOT, 0, 0, 0, 0);
      // empty table: zero-size cube counts as behind, any other straddles
      send_cube(100, -100, 5, 0);
      send_cube(0, 0, 0, 1);
      send_plane(0, 16'sd1024, 0, 0, 0);
      for (int p = 1; p < NUM_PLANES; p++)
         send_plane(3'(p), 0, 0, 0, 16'sd32767);
      // out-of-range entries must not land anywhere
      send_plane(3'd6, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_plane(3'd7, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      // half size 10 gives radius 277: distance exactly on either bound
      send_cube(277, 0, 0, 10);
      send_cube(278, 0, 0, 10);
      send_cube(-277, 0, 0, 10);
      send_cube(-276, 0, 0, 10);
      send_plane(0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_cube(16'sd32767, 16'sd32767, 16'sd32767, 15'd32767);
      send_cube(-16'sd32768, -16'sd32768, -16'sd32768, 15'd32767);
      settle();
   endtask

   task automatic test_omni_sphere();
      set_light(MODE_OMNI, 0, 0, 0, 15'd100);
      send_cube(0, 0, 0, 1);
      // zero-size cube on the sphere surface and just past it
      send_cube(100, 0, 0, 0);
      send_cube(101, 0, 0, 0);
      settle();
      set_light(MODE_OMNI, -16'sd32768, 16'sd32767, -16'sd32768, 15'd32767);
      send_cube(16'sd32767, -16'sd32768, 16'sd32767, 15'd32767);
      send_cube(-16'sd32768, 16'sd32767, -16'sd32768, 0);
      settle();
   endtask

   task automatic test_back_pressure();
      logic signed [15:0] px, py, pz;
      logic [14:0] att;
      px = 16'($urandom);
      py = 16'($urandom);
      pz = 16'($urandom);
      att = 15'($urandom_range(0, 4000));
      set_light(MODE_OMNI, px, py, pz, att);
      sender_idle = 1'b0;
      rsp_hold_left = 400;
      repeat (60) send_omni_cube(px, py, pz, att);
      settle();
      sender_idle = 1'b1;
   endtask

   task automatic test_random_mix();
      logic               mode;
      logic signed [15:0] px, py, pz;
      logic        [14:0] att;
      bit                 box;
      int                 pick;
      for (int phase = 0; phase < 10; phase++) begin
         sender_idle = (phase % 4 == 0) || (phase % 4 == 2);
         receiver_idle = (phase % 4 == 0) || (phase % 4 == 3);
         mode = (phase % 2 == 0) ? MODE_SPOT : MODE_OMNI;
         case (phase)
            2: begin px = -16'sd32768; py = -16'sd32768; pz = -16'sd32768; end
            3: begin px = 16'sd32767; py = 16'sd32767; pz = 16'sd32767; end
            default: begin px = 16'($urandom); py = 16'($urandom); pz = 16'($urandom); end
         endcase
         case (phase)
            3: att = 15'd32767;
            5: att = '0;
            7: att = 15'($urandom);
            default: att = 15'($urandom_range(0, 2000));
         endcase
         set_light(mode, px, py, pz, att);
         if (mode == MODE_SPOT) begin
            box = ($urandom_range(0, 9) < 7);
            for (int p = 0; p < NUM_PLANES; p++)
               send_random_plane(3'(p), box);
         end
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (mode == MODE_SPOT) begin
               if (pick < 8)
                  send_random_plane(3'($urandom_range(0, NUM_PLANES - 1)), box);
               else if (pick < 12)
                  send_random_plane(3'($urandom_range(NUM_PLANES, 7)), 1'b0);
               else
                  send_spot_cube();
            end else begin
               if (pick < 10)
                  send_random_plane(3'($urandom_range(0, 7)), 1'b0);
               else
                  send_omni_cube(px, py, pz, att);
            end
         end
         settle();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_spot_planes();
      test_omni_sphere();
      test_back_pressure();
      test_random_mix();
      $display("%0d items (%0d plane writes) under %0d light settings", item_count,
               plane_write_count, setting_count);
      $display("coverage seen: %0d outside, %0d partial, %0d inside", coverage_seen[0],
               coverage_seen[1], coverage_seen[2]);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> sim.f
hdl/lvc_pkg.sv
hdl/lvc_plane_eval.sv
hdl/lvc_sphere_eval.sv
hdl/light_volume_cube_classify.sv
tb/sv/light_volume_cube_classify_test.sv
